[hdl/soa_pkg.sv]
package soa_pkg;

   localparam int MAX_SLABS        = 16;
   localparam int SLAB_OBJECTS     = 64;
   localparam int NUM_CPUS         = 4;
   localparam int MAGAZINE_DEPTH   = 16;
   localparam int TOTAL_OBJECTS    = MAX_SLABS * SLAB_OBJECTS;

   localparam int SLAB_W   = $clog2(MAX_SLABS);
   localparam int OBJ_W    = $clog2(SLAB_OBJECTS);
   localparam int CPU_W    = $clog2(NUM_CPUS);
   localparam int MAG_W    = $clog2(MAGAZINE_DEPTH);
   localparam int CNT_W    = OBJ_W + 1;
   localparam int MCNT_W   = MAG_W + 1;
   localparam int HANDLE_W = 10;
   localparam int LIMIT_W  = 5;

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [2:0] ST_ALLOC_MAG    = 3'd0;
   localparam logic [2:0] ST_ALLOC_SLAB   = 3'd1;
   localparam logic [2:0] ST_ALLOC_NEW    = 3'd2;
   localparam logic [2:0] ST_OOM          = 3'd3;
   localparam logic [2:0] ST_FREE_MAG     = 3'd4;
   localparam logic [2:0] ST_FREE_SLAB    = 3'd5;
   localparam logic [2:0] ST_FREE_IGNORED = 3'd6;

   typedef struct packed {
      logic                opcode;
      logic [CPU_W-1:0]    cpu;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [HANDLE_W-1:0] object;
   } rsp_type;

endpackage

[hdl/slab_object_allocator.sv]
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+-------------------------------------
// request   | start, busy, req_data          | word taken when start & !busy
// response  | rsp_valid, rsp_data            | one-cycle strobe, cannot be stalled
// config    | csr_valid, csr_ready, csr_wdata| slab_limit written on valid & ready
//
// Each word runs IDLE, READ1, READ2, EXEC; the two read states are set by the two dependent
// reads (slab count, then slab freelist) on the registered-read memories. An alloc that
// creates a slab then runs FILL while its freelist is filled, one entry a cycle.
// After reset busy stays high while the allocated bits are cleared.
// The response is a single-cycle strobe in the cycle after EXEC; the receiver has no stall.
module slab_object_allocator
   import soa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LIMIT_W-1:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_READ1 = 3'd2;
   localparam logic [2:0] S_READ2 = 3'd3;
   localparam logic [2:0] S_EXEC  = 3'd4;
   localparam logic [2:0] S_FILL  = 3'd5;

   localparam int TOT_W = $clog2(TOTAL_OBJECTS);

   // control state
   logic [2:0]            state_ff, state_in;
   logic [TOT_W-1:0]      clr_idx_ff, clr_idx_in;
   logic [OBJ_W-1:0]      fill_idx_ff, fill_idx_in;
   logic [SLAB_W-1:0]     new_slab_ff, new_slab_in;
   req_type               req_ff, req_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [LIMIT_W-1:0]    made_ff, made_in;
   logic [MAX_SLABS-1:0]  nonempty_ff, nonempty_in;
   logic [MCNT_W-1:0]     magcnt_ff [NUM_CPUS];
   logic [MCNT_W-1:0]     magcnt_in [NUM_CPUS];
   logic [SLAB_W-1:0]     pick_ff, pick_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // memories
   logic                  bit_mem [TOTAL_OBJECTS];
   logic [CNT_W-1:0]      cnt_mem [MAX_SLABS];
   logic [OBJ_W-1:0]      stk_mem [TOTAL_OBJECTS];
   logic [HANDLE_W-1:0]   mag_mem [NUM_CPUS*MAGAZINE_DEPTH];

   logic                  bit_rd_ff;
   logic [CNT_W-1:0]      cnt_rd_ff;
   logic [OBJ_W-1:0]      stk_rd_ff;
   logic [HANDLE_W-1:0]   mag_rd_ff;

   logic                  bit_we, bit_wd;
   logic [TOT_W-1:0]      bit_wa;
   logic                  cnt_we;
   logic [SLAB_W-1:0]     cnt_wa, cnt_ra;
   logic [CNT_W-1:0]      cnt_wd;
   logic                  stk_we;
   logic [TOT_W-1:0]      stk_wa, stk_ra;
   logic [OBJ_W-1:0]      stk_wd;
   logic                  mag_we;
   logic [CPU_W+MAG_W-1:0] mag_wa, mag_ra;

   logic [SLAB_W-1:0]     pick_c;
   logic                  found_c;
   logic [MCNT_W-1:0]     mcnt;
   logic [LIMIT_W-1:0]    eff_limit;
   logic [SLAB_W-1:0]     h_slab;
   logic [OBJ_W-1:0]      h_obj;
   logic [CNT_W-1:0]      cnt_dec;
   logic [2:0]            status_c;
   logic [HANDLE_W-1:0]   object_c;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign h_slab  = req_ff.handle[HANDLE_W-1 -: SLAB_W];
   assign h_obj   = req_ff.handle[OBJ_W-1:0];
   assign mcnt    = magcnt_ff[req_ff.cpu];
   assign cnt_dec = cnt_rd_ff - CNT_W'(1);
   assign eff_limit = (limit_ff > LIMIT_W'(MAX_SLABS)) ? LIMIT_W'(MAX_SLABS) : limit_ff;

   // newest slab that still holds free objects
   always_comb begin
      pick_c  = '0;
      found_c = |nonempty_ff;
      for (int i = 0; i < MAX_SLABS; i++) begin
         if (nonempty_ff[i]) pick_c = SLAB_W'(i);
      end
   end

   // read addresses, steady over one word
   assign cnt_ra = (req_ff.opcode == OP_ALLOC) ? pick_c : h_slab;
   assign mag_ra = {req_ff.cpu, MAG_W'(mcnt - MCNT_W'(1))};
   assign stk_ra = {pick_ff, cnt_dec[OBJ_W-1:0]};

   // decide the outcome
   always_comb begin
      status_c = ST_FREE_IGNORED;
      object_c = '0;
      if (req_ff.opcode == OP_ALLOC) begin
         if (mcnt != '0) begin
            status_c = ST_ALLOC_MAG;
            object_c = mag_rd_ff;
         end else if (found_ff) begin
            status_c = ST_ALLOC_SLAB;
            object_c = {pick_ff, stk_rd_ff};
         end else if (made_ff < eff_limit) begin
            status_c = ST_ALLOC_NEW;
            object_c = {made_ff[SLAB_W-1:0], OBJ_W'(0)};
         end else begin
            status_c = ST_OOM;
         end
      end else begin
         if (!bit_rd_ff) begin
            status_c = ST_FREE_IGNORED;
         end else if (mcnt < MCNT_W'(MAGAZINE_DEPTH)) begin
            status_c = ST_FREE_MAG;
         end else if (cnt_rd_ff >= CNT_W'(SLAB_OBJECTS)) begin
            status_c = ST_FREE_IGNORED;
         end else begin
            status_c = ST_FREE_SLAB;
         end
      end
   end

   // next state and memory writes
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      fill_idx_in  = fill_idx_ff;
      new_slab_in  = new_slab_ff;
      req_in       = req_ff;
      limit_in     = limit_ff;
      made_in      = made_ff;
      nonempty_in  = nonempty_ff;
      magcnt_in    = magcnt_ff;
      pick_in      = pick_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      bit_we = 1'b0;  bit_wa = req_ff.handle;  bit_wd = 1'b0;
      cnt_we = 1'b0;  cnt_wa = h_slab;         cnt_wd = '0;
      stk_we = 1'b0;  stk_wa = '0;             stk_wd = '0;
      mag_we = 1'b0;  mag_wa = {req_ff.cpu, mcnt[MAG_W-1:0]};

      if (csr_valid) limit_in = csr_wdata;

      case (state_ff)
         S_CLEAR: begin
            bit_we     = 1'b1;
            bit_wa     = clr_idx_ff;
            clr_idx_in = clr_idx_ff + TOT_W'(1);
            if (clr_idx_ff == TOT_W'(TOTAL_OBJECTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_READ1;
            end
         end
         S_READ1: begin
            pick_in  = pick_c;
            found_in = found_c;
            state_in = S_READ2;
         end
         S_READ2: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: status_c, object: object_c};
            state_in     = S_IDLE;
            case (status_c)
               ST_ALLOC_MAG: begin
                  magcnt_in[req_ff.cpu] = mcnt - MCNT_W'(1);
                  bit_we = 1'b1;  bit_wa = object_c;  bit_wd = 1'b1;
               end
               ST_ALLOC_SLAB: begin
                  cnt_we = 1'b1;  cnt_wa = pick_ff;  cnt_wd = cnt_dec;
                  nonempty_in[pick_ff] = (cnt_dec != '0);
                  bit_we = 1'b1;  bit_wa = object_c;  bit_wd = 1'b1;
               end
               ST_ALLOC_NEW: begin
                  // object 0 leaves at once; fill the freelist next
                  cnt_we = 1'b1;
                  cnt_wa = made_ff[SLAB_W-1:0];
                  cnt_wd = CNT_W'(SLAB_OBJECTS - 1);
                  nonempty_in[made_ff[SLAB_W-1:0]] = 1'b1;
                  made_in     = made_ff + LIMIT_W'(1);
                  new_slab_in = made_ff[SLAB_W-1:0];
                  fill_idx_in = '0;
                  bit_we = 1'b1;  bit_wa = object_c;  bit_wd = 1'b1;
                  state_in = S_FILL;
               end
               ST_FREE_MAG: begin
                  mag_we = 1'b1;
                  magcnt_in[req_ff.cpu] = mcnt + MCNT_W'(1);
                  bit_we = 1'b1;
               end
               ST_FREE_SLAB: begin
                  stk_we = 1'b1;
                  stk_wa = {h_slab, cnt_rd_ff[OBJ_W-1:0]};
                  stk_wd = h_obj;
                  cnt_we = 1'b1;  cnt_wd = cnt_rd_ff + CNT_W'(1);
                  nonempty_in[h_slab] = 1'b1;
                  bit_we = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_FILL: begin
            // entry i holds object SLAB_OBJECTS-1-i
            stk_we      = 1'b1;
            stk_wa      = {new_slab_ff, fill_idx_ff};
            stk_wd      = ~fill_idx_ff;
            fill_idx_in = fill_idx_ff + OBJ_W'(1);
            if (fill_idx_ff == OBJ_W'(SLAB_OBJECTS - 1)) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         limit_ff     <= LIMIT_W'(16);
         made_ff      <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CPUS; c++) magcnt_ff[c] <= '0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         limit_ff     <= limit_in;
         made_ff      <= made_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
         magcnt_ff    <= magcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_idx_ff <= fill_idx_in;
      new_slab_ff <= new_slab_in;
      req_ff      <= req_in;
      pick_ff     <= pick_in;
      found_ff    <= found_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (bit_we) bit_mem[bit_wa] <= bit_wd;
      bit_rd_ff <= bit_mem[req_ff.handle];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (mag_we) mag_mem[mag_wa] <= req_ff.handle;
      mag_rd_ff <= mag_mem[mag_ra];
   end

endmodule

[sim/slab_checker.sv]
`timescale 1ns / 100ps

module slab_checker
   import soa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  rsp_type            rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_wdata,
   output int                 fail_count,
   output int                 pending_count,
   output int                 status_seen [8]
);

   logic [LIMIT_W-1:0] limit_reg;
   int                 slabs_made;
   int                 slab_free_count [MAX_SLABS];
   int                 slab_free_stack [TOTAL_OBJECTS];
   bit                 allocated_bit [TOTAL_OBJECTS];
   int                 mag_count [NUM_CPUS];
   int                 mag_store [NUM_CPUS*MAGAZINE_DEPTH];
   rsp_type            expected_rsp_q [$];

   function automatic int pop_slab(int s);
      int n;
      n = slab_free_count[s] - 1;
      slab_free_count[s] = n;
      return s * SLAB_OBJECTS + slab_free_stack[s*SLAB_OBJECTS + n];
   endfunction

   function automatic rsp_type allocate_or_free(req_type r);
      rsp_type o;
      int      c, s, lim, n;
      o = '0;
      c = r.cpu;
      if (r.opcode == OP_ALLOC) begin
         if (mag_count[c] > 0) begin
            mag_count[c]--;
            o.object = mag_store[c*MAGAZINE_DEPTH + mag_count[c]];
            o.status = ST_ALLOC_MAG;
         end else begin
            s = slabs_made - 1;
            while (s >= 0 && slab_free_count[s] == 0) s--;
            lim = (limit_reg < MAX_SLABS) ? limit_reg : MAX_SLABS;
            if (s >= 0) begin
               o.object = pop_slab(s);
               o.status = ST_ALLOC_SLAB;
            end else if (slabs_made < lim) begin
               for (int i = 0; i < SLAB_OBJECTS; i++)
                  slab_free_stack[slabs_made*SLAB_OBJECTS + i] = SLAB_OBJECTS - 1 - i;
               slab_free_count[slabs_made] = SLAB_OBJECTS;
               slabs_made++;
               o.object = pop_slab(slabs_made - 1);
               o.status = ST_ALLOC_NEW;
            end else begin
               o.status = ST_OOM;
            end
         end
         if (o.status != ST_OOM) allocated_bit[o.object] = 1'b1;
      end else begin
         if (r.handle >= TOTAL_OBJECTS || !allocated_bit[r.handle]) begin
            o.status = ST_FREE_IGNORED;
         end else if (mag_count[c] < MAGAZINE_DEPTH) begin
            allocated_bit[r.handle] = 1'b0;
            mag_store[c*MAGAZINE_DEPTH + mag_count[c]] = r.handle;
            mag_count[c]++;
            o.status = ST_FREE_MAG;
         end else begin
            s = r.handle / SLAB_OBJECTS;
            n = slab_free_count[s];
            if (n >= SLAB_OBJECTS) begin
               o.status = ST_FREE_IGNORED;
            end else begin
               allocated_bit[r.handle] = 1'b0;
               slab_free_stack[s*SLAB_OBJECTS + n] = r.handle % SLAB_OBJECTS;
               slab_free_count[s] = n + 1;
               o.status = ST_FREE_SLAB;
            end
         end
      end
      return o;
   endfunction

   initial pending_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         limit_reg  <= 5'd16;
         slabs_made  = 0;
         fail_count  = 0;
         foreach (mag_count[i]) mag_count[i] = 0;
         foreach (allocated_bit[i]) allocated_bit[i] = 1'b0;
         foreach (slab_free_count[i]) slab_free_count[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response word status=%0d object=%0d",
                      rsp_data.status, rsp_data.object);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               status_seen[want.status]++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.object !== want.object) begin
                  $error("object: expected %0d, got %0d", want.object, rsp_data.object);
                  fail_count++;
               end
            end
         end
         if (start && !busy) expected_rsp_q.push_back(allocate_or_free(req_data));
         if (csr_valid && csr_ready) limit_reg <= csr_wdata;
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import soa_pkg::*;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_wdata;
   int                 fail_count;
   int                 pending_count;
   int                 status_seen [8];
   int                 cycle_count;
   int                 words_sent;
   // host-side copy of live handles, so most frees hit allocated objects
   int                 live_handles [$];

   slab_object_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   slab_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .status_seen   (status_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: covers the clear pass, words that fill a new slab, and long gaps.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("slab_object_allocator regression: fail");
            $finish;
         end
      end
   end

   // Insert an idle gap: often none, else mostly short, sometimes long.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 5) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      repeat (n) @(negedge clock);
   endtask

   // Hold start until the word is taken, then drop it.
   task automatic send_word(logic op, int cpu, int handle);
      req_data.opcode = op;
      req_data.cpu    = cpu[CPU_W-1:0];
      req_data.handle = handle[HANDLE_W-1:0];
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start = 1'b0;
      words_sent++;
   endtask

   task automatic do_alloc(int cpu);
      send_word(OP_ALLOC, cpu, $urandom_range(0, 1023));
   endtask

   // Free a live handle, or a stray one for the ignore path.
   task automatic do_free(int cpu, bit stray);
      int k, h;
      if (stray || live_handles.size() == 0) begin
         h = $urandom_range(0, 1023);
      end else begin
         k = $urandom_range(0, live_handles.size() - 1);
         h = live_handles[k];
         live_handles.delete(k);
      end
      send_word(OP_FREE, cpu, h);
   endtask

   // Track handles handed out so frees can pick them.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_data.status <= ST_ALLOC_NEW)
         live_handles.push_back(rsp_data.object);

   // Drain outstanding words and let the block settle before a register write.
   task automatic wait_idle();
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_limit(int value);
      wait_idle();
      csr_wdata <= value[LIMIT_W-1:0];
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_limit [5] = '{1, 31, 3, 0, 16};
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_wdata  = '0;
      words_sent = 0;
      reset      = 1'b1;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: one-slab limit, exhaust it, out of memory, frees both ways.
      write_limit(1);
      do_alloc(0);
      do_alloc(3);
      send_word(OP_FREE, 0, 1023);   // never allocated
      send_word(OP_FREE, 1, 0);      // to magazine
      send_word(OP_FREE, 1, 0);      // double free
      do_alloc(1);                   // from magazine
      do_alloc(2);                   // from slab freelist
      send_word(OP_FREE, 2, 1023);
      wait_idle();
      repeat (62) do_alloc(0);       // drain the slab, then out of memory
      // Fill cpu 0 magazine to its depth and spill onto the slab freelist.
      repeat (18) do_free(0, 1'b0);
      do_alloc(0);

      // Random phases across several limits, extremes included.
      foreach (phase_limit[p]) begin
         write_limit(phase_limit[p]);
         repeat (200) begin
            int r;
            idle_gap();
            r = $urandom_range(0, 99);
            if (r < 50) do_alloc($urandom_range(0, 3));
            else if (r < 92) do_free($urandom_range(0, 3), 1'b0);
            else do_free($urandom_range(0, 3), 1'b1);
         end
      end

      wait_idle();
      $display("sent %0d words over slab limits 1, 31, 3, 0, 16", words_sent);
      $display("status counts: mag %0d slab %0d new %0d oom %0d fmag %0d fslab %0d ign %0d",
               status_seen[ST_ALLOC_MAG], status_seen[ST_ALLOC_SLAB],
               status_seen[ST_ALLOC_NEW], status_seen[ST_OOM],
               status_seen[ST_FREE_MAG], status_seen[ST_FREE_SLAB],
               status_seen[ST_FREE_IGNORED]);
      if (fail_count == 0)
         $display("slab_object_allocator regression: pass");
      else
         $display("slab_object_allocator regression: fail");
      $finish;
   end

endmodule

[files.f]
hdl/soa_pkg.sv
hdl/slab_object_allocator.sv
sim/slab_checker.sv
sim/testbench.sv
